>>> rtl/core/cwtf_pkg.sv
`timescale 1ns / 1ps

package cwtf_pkg;

   localparam int TS_W     = 64;
   localparam int MOD_W    = 12;
   localparam int TAG_W    = 16;
   localparam int WIN_W    = 32;
   localparam int THR_W    = 13;
   localparam int CSR_IW   = 2;
   localparam int CSR_DW   = 32;

   localparam int BUFFER_DEPTH_DEFAULT = 32;
   localparam int MODULE_SLOTS_DEFAULT = 4096;

   localparam logic [CSR_IW-1:0] CSR_FILTER_ENABLE    = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_SEARCH_WINDOW    = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_MODULE_THRESHOLD = 2'd2;

   typedef struct packed {
      logic [TS_W-1:0]  timestamp;
      logic [MOD_W-1:0] module_id;
      logic [TAG_W-1:0] trigger_tag;
      logic             end_of_slice;
   } cwtf_req_type;

   typedef struct packed {
      logic [TAG_W-1:0] decided_tag;
      logic             keep;
      logic             overflow;
      logic             last;
   } cwtf_rsp_type;

   typedef struct packed {
      logic             filter_enable;
      logic [WIN_W-1:0] search_window;
      logic [THR_W-1:0] module_threshold;
   } cwtf_cfg_type;

   typedef struct packed {
      logic clear;         // zero one slot-table entry after reset
      logic load_in;       // capture the accepted trigger
      logic capture;       // register slot and first module lookup
      logic flush_start;   // rewind the buffer read index
      logic emit_flush;    // send one buffered decision
      logic last_group;    // this flush ends the trigger's decisions
      logic flush_clear;   // empty the cluster
      logic close_window;  // end of slice: window closes
      logic mark;          // add the trigger to the cluster
      logic emit_ovf;      // send the overflow decision
   } cwtf_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic gap_hit;
      logic ovf;
      logic eos;
      logic idx_at_end;
      logic out_free;
   } cwtf_status_type;

endpackage

>>> rtl/core/cwtf_csr.sv
`timescale 1ns / 1ps

module cwtf_csr
   import cwtf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_data,
   output cwtf_cfg_type      cfg
);

   cwtf_cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FILTER_ENABLE:    cfg_in.filter_enable    = csr_data[0];
            CSR_SEARCH_WINDOW:    cfg_in.search_window    = csr_data[WIN_W-1:0];
            CSR_MODULE_THRESHOLD: cfg_in.module_threshold = csr_data[THR_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_enable    <= 1'b0;
         cfg_ff.search_window    <= '0;
         cfg_ff.module_threshold <= THR_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/core/cwtf_ctrl.sv
`timescale 1ns / 1ps

module cwtf_ctrl
   import cwtf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  cwtf_status_type sts,
   output cwtf_cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b00000001,
      ST_CHECK   = 8'b00000010,
      ST_TOUCH   = 8'b00000100,
      ST_FL_RD   = 8'b00001000,
      ST_FL_EMIT = 8'b00010000,
      ST_MARK    = 8'b00100000,
      ST_OVF     = 8'b01000000,
      ST_CLEAR   = 8'b10000000
   } cwtf_state_type;

   cwtf_state_type state_ff, state_in;
   logic           eos_flush_ff, eos_flush_in;

   always_comb begin
      state_in     = state_ff;
      eos_flush_in = eos_flush_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            // slot-to-position table is zeroed once after reset
            cmd.clear = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.capture = 1'b1;
            state_in    = ST_TOUCH;
         end
         ST_TOUCH: begin
            if (sts.gap_hit) begin
               cmd.flush_start = 1'b1;
               eos_flush_in    = 1'b0;
               state_in        = ST_FL_RD;
            end else begin
               state_in = ST_MARK;
            end
         end
         ST_FL_RD: begin
            // tag buffer read settles on the new index
            state_in = ST_FL_EMIT;
         end
         ST_FL_EMIT: begin
            if (sts.idx_at_end) begin
               cmd.flush_clear  = 1'b1;
               cmd.close_window = eos_flush_ff;
               state_in         = eos_flush_ff ? ST_IDLE : ST_MARK;
            end else if (sts.out_free) begin
               cmd.emit_flush = 1'b1;
               // a gap flush is followed by the end-of-slice flush when eos is set
               cmd.last_group = eos_flush_ff || !sts.eos;
               state_in       = ST_FL_RD;
            end
         end
         ST_MARK: begin
            cmd.mark = 1'b1;
            if (sts.ovf) begin
               state_in = ST_OVF;
            end else if (sts.eos) begin
               cmd.flush_start = 1'b1;
               eos_flush_in    = 1'b1;
               state_in        = ST_FL_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OVF: begin
            if (sts.out_free) begin
               cmd.emit_ovf = 1'b1;
               if (sts.eos) begin
                  cmd.flush_start = 1'b1;
                  eos_flush_in    = 1'b1;
                  state_in        = ST_FL_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         eos_flush_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eos_flush_ff <= eos_flush_in;
      end
   end

endmodule

>>> rtl/core/cwtf_dp.sv
`timescale 1ns / 1ps

module cwtf_dp
   import cwtf_pkg::*;
#(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT,
   parameter int MODULE_SLOTS = MODULE_SLOTS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  cwtf_req_type    req_data,
   input  cwtf_cfg_type    cfg,
   input  cwtf_cmd_type    cmd,
   output cwtf_status_type sts,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output cwtf_rsp_type    rsp_data
);

   localparam int CNT_W   = $clog2(BUFFER_DEPTH + 1);
   localparam int BUF_AW  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int SLOT_W  = $clog2(MODULE_SLOTS);
   localparam int DCNT_W  = $clog2(MODULE_SLOTS + 1);
   // exact floor(id / MODULE_SLOTS) by reciprocal for 12-bit ids
   localparam int SH      = MOD_W + SLOT_W;
   localparam int RECIP_W = MOD_W + 2;
   localparam int RECIP   = (2 ** SH + MODULE_SLOTS - 1) / MODULE_SLOTS;
   localparam int PROD_W  = MOD_W + RECIP_W;

   // pending trigger tags
   logic [TAG_W-1:0]  tag_mem [BUFFER_DEPTH];
   // sparse set of seen modules: slot -> position, position -> slot
   logic [SLOT_W-1:0] seen_mem  [MODULE_SLOTS];
   logic [SLOT_W-1:0] touch_mem [MODULE_SLOTS];

   cwtf_req_type      in_ff, in_in;
   logic [MOD_W-1:0]  q_ff, q_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] pos_ff;
   logic [SLOT_W-1:0] tslot_ff;
   logic [TAG_W-1:0]  tag_rd_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [DCNT_W-1:0] distinct_ff, distinct_in;
   logic [TS_W-1:0]   prev_ff, prev_in;
   logic              wopen_ff, wopen_in;
   logic              rsp_valid_ff, rsp_valid_in;
   cwtf_rsp_type      rsp_ff, rsp_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;

   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] qm;
   logic [PROD_W-1:0] rem;
   logic [SLOT_W-1:0] slot_comb;
   logic              member;
   logic              keep_val;
   logic              idx_last;

   always_comb begin
      prod      = PROD_W'(req_data.module_id) * PROD_W'(RECIP);
      qm        = PROD_W'(q_ff) * PROD_W'(MODULE_SLOTS);
      rem       = PROD_W'(in_ff.module_id) - qm;
      slot_comb = rem[SLOT_W-1:0];

      member   = (DCNT_W'(pos_ff) < distinct_ff) && (tslot_ff == slot_ff);
      keep_val = !cfg.filter_enable || (THR_W'(distinct_ff) >= cfg.module_threshold);
      idx_last = (idx_ff + CNT_W'(1)) == count_ff;

      sts.clear_done = clr_ff == SLOT_W'(MODULE_SLOTS - 1);
      sts.gap_hit    = wopen_ff &&
                       ((in_ff.timestamp - prev_ff) > TS_W'(cfg.search_window));
      sts.ovf        = count_ff == CNT_W'(BUFFER_DEPTH);
      sts.eos        = in_ff.end_of_slice;
      sts.idx_at_end = idx_ff == count_ff;
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      clr_in      = cmd.clear ? clr_ff + SLOT_W'(1) : clr_ff;
      in_in       = cmd.load_in ? req_data : in_ff;
      q_in        = cmd.load_in ? MOD_W'(prod >> SH) : q_ff;
      slot_in     = cmd.capture ? slot_comb : slot_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      distinct_in = distinct_ff;
      prev_in     = prev_ff;
      wopen_in    = wopen_ff;

      if (cmd.flush_start) begin
         idx_in = '0;
      end
      if (cmd.emit_flush) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (cmd.flush_clear) begin
         count_in    = '0;
         distinct_in = '0;
      end
      if (cmd.close_window) begin
         wopen_in = 1'b0;
         prev_in  = '0;
      end
      if (cmd.mark) begin
         prev_in  = in_ff.timestamp;
         wopen_in = 1'b1;
         if (!member) begin
            distinct_in = distinct_ff + DCNT_W'(1);
         end
         if (!sts.ovf) begin
            count_in = count_ff + CNT_W'(1);
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (cmd.emit_flush) begin
         rsp_valid_in       = 1'b1;
         rsp_in.decided_tag = tag_rd_ff;
         rsp_in.keep        = keep_val;
         rsp_in.overflow    = 1'b0;
         rsp_in.last        = cmd.last_group && idx_last;
      end else if (cmd.emit_ovf) begin
         rsp_valid_in       = 1'b1;
         rsp_in.decided_tag = in_ff.trigger_tag;
         rsp_in.keep        = 1'b1;
         rsp_in.overflow    = 1'b1;
         rsp_in.last        = !in_ff.end_of_slice;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         distinct_ff  <= '0;
         prev_ff      <= '0;
         wopen_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         distinct_ff  <= distinct_in;
         prev_ff      <= prev_in;
         wopen_ff     <= wopen_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff   <= in_in;
      q_ff    <= q_in;
      slot_ff <= slot_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pos_ff <= seen_mem[slot_comb];
      end
      if (cmd.clear) begin
         seen_mem[clr_ff] <= '0;
      end else if (cmd.mark && !member) begin
         seen_mem[slot_ff] <= distinct_ff[SLOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      tslot_ff <= touch_mem[pos_ff];
      if (cmd.mark && !member) begin
         touch_mem[distinct_ff[SLOT_W-1:0]] <= slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      tag_rd_ff <= tag_mem[idx_ff[BUF_AW-1:0]];
      if (cmd.mark && !sts.ovf) begin
         tag_mem[count_ff[BUF_AW-1:0]] <= in_ff.trigger_tag;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/core/coincidence_window_trigger_filter.sv
`timescale 1ns / 1ps

// Coincidence trigger filter: time-sorted triggers are grouped into clusters
// (a gap above search_window, or end_of_slice, closes one), and on close one
// decision per buffered trigger goes out in arrival order, kept when the
// filter is off or the cluster saw at least module_threshold distinct modules.
// A trigger that meets a full buffer is passed at once as kept with overflow
// set. Decision order for one trigger: the cluster its gap closed, then its
// overflow decision, then the end-of-slice cluster; last marks the final one.
// A trigger that closes nothing passes through capture, slot reduce and first
// module lookup, second lookup and update, set by the two registered reads of
// the module-tracking memories. An overflow decision adds a state that waits
// for a free output register; each cluster close adds a tag-buffer read and an
// emit state per buffered trigger, as the tag buffer has a registered read.
// Distinct modules are tracked as a sparse set indexed by a fill count, so a
// cluster close needs no clearing; after reset one pass over all MODULE_SLOTS
// entries zeroes the slot-to-position table, and req_ready stays low until it
// is done. Results wait in an output register; a stalled rsp side holds the
// block only when a decision must be sent.

module coincidence_window_trigger_filter
   import cwtf_pkg::*;
#(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT,
   parameter int MODULE_SLOTS = MODULE_SLOTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cwtf_req_type      req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cwtf_rsp_type      rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_data
);

   cwtf_cfg_type    cfg;
   cwtf_cmd_type    cmd;
   cwtf_status_type sts;

   cwtf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cwtf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cwtf_dp #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .MODULE_SLOTS (MODULE_SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/core/cwtf_checker.sv
`timescale 1ns / 1ps

module cwtf_checker
   import cwtf_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input cwtf_rsp_type      rsp_data
);

   // nothing leaves the block right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a trigger is worked on alone: no transfer in the cycle after one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after a transfer");

   // a trigger passed on overflow is always kept
   a_ovf_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |-> rsp_data.keep)
      else $error("overflow decision not kept");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled decision changed");

endmodule

bind coincidence_window_trigger_filter cwtf_checker u_cwtf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> bench/cluster_decision_checker.sv
`timescale 1ns / 1ps

module cluster_decision_checker
   import cwtf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  cwtf_req_type      req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  cwtf_rsp_type      rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_data,
   output int unsigned       mismatch_count,
   output int unsigned       decisions_outstanding
);

   // predictor copy of the configuration
   logic             filt_on;
   logic [WIN_W-1:0] window_ticks;
   logic [THR_W-1:0] min_modules;

   // open cluster
   logic [TAG_W-1:0] held_tags[$];
   bit               module_hit[MODULE_SLOTS_DEFAULT];
   int unsigned      module_total;
   logic [TS_W-1:0]  last_time;
   bit               cluster_open;

   cwtf_rsp_type     expected_decisions[$];
   int unsigned      mismatch_total;

   function automatic void empty_cluster();
      held_tags.delete();
      module_total = 0;
      foreach (module_hit[i]) module_hit[i] = 1'b0;
   endfunction

   function automatic void close_cluster();
      cwtf_rsp_type d;
      logic         keep_all;
      keep_all = !filt_on || (module_total >= min_modules);
      foreach (held_tags[i]) begin
         d.decided_tag = held_tags[i];
         d.keep = keep_all;
         d.overflow = 1'b0;
         d.last = 1'b0;
         expected_decisions.insert(expected_decisions.size(), d);
      end
      empty_cluster();
   endfunction

   function automatic void predict_decisions(input cwtf_req_type t);
      int unsigned     first_new;
      int unsigned     slot;
      logic [TS_W-1:0] gap;
      cwtf_rsp_type    d;
      first_new = expected_decisions.size();
      gap = t.timestamp - last_time;   // wraps modulo 2^64
      if (cluster_open && gap > {{(TS_W-WIN_W){1'b0}}, window_ticks})
         close_cluster();
      slot = t.module_id % MODULE_SLOTS_DEFAULT;
      if (!module_hit[slot]) begin
         module_hit[slot] = 1'b1;
         module_total++;
      end
      if (held_tags.size() < BUFFER_DEPTH_DEFAULT) begin
         held_tags.insert(held_tags.size(), t.trigger_tag);
      end else begin
         // buffer full: passes straight through, module still counted
         d.decided_tag = t.trigger_tag;
         d.keep = 1'b1;
         d.overflow = 1'b1;
         d.last = 1'b0;
         expected_decisions.insert(expected_decisions.size(), d);
      end
      last_time = t.timestamp;
      cluster_open = 1'b1;
      if (t.end_of_slice) begin
         close_cluster();
         cluster_open = 1'b0;
         last_time = '0;
      end
      if (expected_decisions.size() > first_new) begin
         d = expected_decisions.pop_back();
         d.last = 1'b1;
         expected_decisions.insert(expected_decisions.size(), d);
      end
   endfunction

   always @(posedge clock) begin : check_proc
      cwtf_rsp_type want;
      if (reset) begin
         filt_on = 1'b0;
         window_ticks = '0;
         min_modules = THR_W'(1);
         empty_cluster();
         last_time = '0;
         cluster_open = 1'b0;
         expected_decisions.delete();
         mismatch_total = 0;
      end else begin
         // compare before predicting: a decision never belongs to a trigger
         // accepted at the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_decisions.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("unexpected decision: tag %h keep %b overflow %b last %b",
                           rsp_data.decided_tag, rsp_data.keep, rsp_data.overflow,
                           rsp_data.last);
            end else begin
               want = expected_decisions.pop_front();
               if (rsp_data.decided_tag !== want.decided_tag ||
                   rsp_data.keep !== want.keep ||
                   rsp_data.overflow !== want.overflow ||
                   rsp_data.last !== want.last) begin
                  mismatch_total++;
                  if (mismatch_total <= 10)
                     $display({"decision mismatch: expected tag %h keep %b ovf %b last %b,",
                               " got tag %h keep %b ovf %b last %b"},
                              want.decided_tag, want.keep, want.overflow, want.last,
                              rsp_data.decided_tag, rsp_data.keep, rsp_data.overflow,
                              rsp_data.last);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FILTER_ENABLE: filt_on = csr_data[0];
               CSR_SEARCH_WINDOW: window_ticks = csr_data[WIN_W-1:0];
               CSR_MODULE_THRESHOLD: min_modules = csr_data[THR_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_decisions(req_data);
      end
      mismatch_count <= mismatch_total;
      decisions_outstanding <= expected_decisions.size();
   end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import cwtf_pkg::*;

   localparam logic [CSR_IW-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam int unsigned CYCLE_LIMIT   = 300000;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned PHASE_ITEMS   = 40;
   localparam int unsigned FLOOD_ITEMS   = 40;

   typedef enum int unsigned {
      FLOW_FREE, FLOW_COIN, FLOW_SPARSE, FLOW_PERIODIC
   } flow_mode_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   cwtf_req_type      req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   cwtf_rsp_type      rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_data = '0;

   int unsigned       mismatches;
   int unsigned       outstanding;
   bit                hold_request = 1'b0;
   int unsigned       burst_left = 0;
   logic [TS_W-1:0]   now_ticks = '0;
   logic [WIN_W-1:0]  cur_window = '0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   coincidence_window_trigger_filter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   cluster_decision_checker decision_check (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_data              (req_data),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_data              (rsp_data),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .mismatch_count        (mismatches),
      .decisions_outstanding (outstanding)
   );

   // sender: bursts of transfers separated by random gaps
   task automatic push_trigger(input logic [TS_W-1:0] ts, input logic [MOD_W-1:0] mod,
                               input logic [TAG_W-1:0] tag, input logic eos);
      cwtf_req_type item;
      int unsigned  idle;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (idle) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      burst_left--;
      item.timestamp = ts;
      item.module_id = mod;
      item.trigger_tag = tag;
      item.end_of_slice = eos;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IW-1:0] idx, input logic [CSR_DW-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait until every decision has come back, then let triggers that
   // produce nothing finish inside the block
   task automatic drain_all();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic random_phase();
      int unsigned      made;
      int unsigned      run_len;
      int unsigned      pool_size;
      logic [MOD_W-1:0] pool_base;
      logic [MOD_W-1:0] mod;
      logic             eos;
      logic [WIN_W-1:0] near;
      logic [WIN_W-1:0] step;
      logic [CSR_DW-1:0] value;
      logic [THR_W-1:0] thr;
      drain_all();
      write_reg(CSR_FILTER_ENABLE, $urandom);
      case ($urandom_range(0, 3))
         0: cur_window = '0;
         1: cur_window = $urandom_range(1, 20);
         2: cur_window = $urandom;
         default: cur_window = '1;
      endcase
      write_reg(CSR_SEARCH_WINDOW, cur_window);
      case ($urandom_range(0, 6))
         0: thr = THR_W'(0);
         1: thr = THR_W'(1);
         2: thr = THR_W'(2);
         3: thr = THR_W'(3);
         4: thr = THR_W'($urandom_range(1, 6));
         5: thr = THR_W'(4096);
         default: thr = '1;
      endcase
      value = $urandom;
      value[THR_W-1:0] = thr;
      write_reg(CSR_MODULE_THRESHOLD, value);
      if ($urandom_range(0, 1) == 0)
         write_reg(CSR_SPARE_INDEX, $urandom);
      pool_base = MOD_W'($urandom);
      pool_size = $urandom_range(1, 6);
      made = 0;
      while (made < PHASE_ITEMS) begin
         run_len = $urandom_range(1, 8);
         for (int k = 0; k < run_len; k++) begin
            if ($urandom_range(0, 7) == 0)
               mod = MOD_W'($urandom);
            else
               mod = pool_base + MOD_W'($urandom_range(0, pool_size - 1));
            eos = (k == run_len - 1) && ($urandom_range(0, 2) == 0);
            push_trigger(now_ticks, mod, TAG_W'($urandom_range(0, 65535)), eos);
            made++;
            if (k < run_len - 1) begin
               // stay inside the window, sometimes right at its edge
               near = (cur_window < 20) ? cur_window : 20;
               step = ($urandom_range(0, 4) == 0) ? cur_window : $urandom_range(0, near);
               now_ticks = now_ticks + {{(TS_W-WIN_W){1'b0}}, step};
            end else begin
               now_ticks = now_ticks + {{(TS_W-WIN_W){1'b0}}, cur_window} + 64'd1 +
                           64'($urandom_range(0, 30));
            end
         end
         // noise: jump anywhere, backwards included
         if ($urandom_range(0, 9) == 0)
            now_ticks = {$urandom, $urandom};
      end
   endtask

   // receiver: stall pattern of its own, plus one long hold on request
   initial begin : rsp_side
      flow_mode_type mode;
      int unsigned   mode_left;
      int unsigned   hold_left;
      bit            hold_taken;
      mode = FLOW_FREE;
      mode_left = 0;
      hold_left = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode = flow_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               FLOW_FREE: rsp_ready <= 1'b1;
               FLOW_COIN: rsp_ready <= ($urandom_range(0, 1) == 1);
               FLOW_SPARSE: rsp_ready <= ($urandom_range(0, 5) == 0);
               default: rsp_ready <= (mode_left % 3 != 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: filter off, zero window
      push_trigger(64'd0, 12'h000, 16'h0000, 1'b0);
      push_trigger(64'd0, 12'hFFF, 16'hFFFF, 1'b0);     // zero gap joins
      push_trigger(64'd1, 12'h001, 16'h0001, 1'b1);     // gap closes, then slice end

      // widest window; a gap equal to the window still joins
      drain_all();
      write_reg(CSR_FILTER_ENABLE, 32'hFFFF_FFFF);
      write_reg(CSR_SEARCH_WINDOW, 32'hFFFF_FFFF);
      write_reg(CSR_MODULE_THRESHOLD, 32'd2);
      push_trigger(64'd100, 12'h005, 16'h0010, 1'b0);
      push_trigger(64'h1_0000_0063, 12'h005, 16'h0011, 1'b0);
      push_trigger(64'h2_0000_0063, 12'h006, 16'h0012, 1'b0);   // one past: drops 1-module cluster
      push_trigger(64'h2_0000_0063, 12'h007, 16'h0013, 1'b1);
      push_trigger(64'hFFFF_FFFF_FFFF_FFFF, 12'h008, 16'h0014, 1'b0);
      push_trigger(64'd0, 12'h009, 16'h0015, 1'b1);     // wrapped gap of one joins

      // threshold zero keeps all; timestamp going backwards closes
      drain_all();
      write_reg(CSR_SEARCH_WINDOW, 32'd0);
      write_reg(CSR_MODULE_THRESHOLD, 32'd0);
      push_trigger(64'd50, 12'h003, 16'h0020, 1'b0);
      push_trigger(64'd40, 12'h003, 16'h0021, 1'b0);
      push_trigger(64'd40, 12'h003, 16'h0022, 1'b1);

      // threshold beyond any possible count, spare index ignored
      drain_all();
      write_reg(CSR_MODULE_THRESHOLD, 32'hFFFF_FFFF);
      write_reg(CSR_SEARCH_WINDOW, 32'd10);
      write_reg(CSR_SPARE_INDEX, 32'h0000_0000);
      push_trigger(64'd1000, 12'h001, 16'h0030, 1'b0);
      push_trigger(64'd1005, 12'h002, 16'h0031, 1'b0);
      push_trigger(64'd1010, 12'h004, 16'h0032, 1'b1);

      drain_all();
      write_reg(CSR_MODULE_THRESHOLD, 32'hFFFF_F000);  // 4096 after masking
      push_trigger(64'd2000, 12'hABC, 16'h0040, 1'b1);
      drain_all();
      write_reg(CSR_FILTER_ENABLE, 32'hFFFF_FFFE);     // filter off
      push_trigger(64'd2001, 12'h543, 16'h0041, 1'b0);
      push_trigger(64'd2002, 12'h543, 16'h0042, 1'b1);

      // threshold met exactly, repeated module counted once
      drain_all();
      write_reg(CSR_FILTER_ENABLE, 32'd1);
      write_reg(CSR_SEARCH_WINDOW, 32'd5);
      write_reg(CSR_MODULE_THRESHOLD, 32'd3);
      push_trigger(64'd3000, 12'h800, 16'h0050, 1'b0);
      push_trigger(64'd3005, 12'h7FF, 16'h0051, 1'b0);
      push_trigger(64'd3005, 12'h800, 16'h0052, 1'b0);
      push_trigger(64'd3010, 12'h001, 16'h0053, 1'b0);
      push_trigger(64'd3016, 12'h002, 16'h0054, 1'b1);

      // long receiver hold while one cluster overruns the buffer
      drain_all();
      write_reg(CSR_SEARCH_WINDOW, 32'd1000);
      write_reg(CSR_MODULE_THRESHOLD, 32'd2);
      cur_window = 32'd1000;
      now_ticks = 64'd5000;
      hold_request = 1'b1;
      for (int n = 0; n < FLOOD_ITEMS; n++) begin
         push_trigger(now_ticks, MOD_W'($urandom), TAG_W'($urandom_range(0, 65535)),
                      n == FLOOD_ITEMS - 1);
         now_ticks = now_ticks + 64'($urandom_range(0, 3));
      end

      now_ticks = {$urandom, $urandom};
      for (int p = 0; p < RANDOM_PHASES; p++)
         random_phase();

      drain_all();
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/cwtf_pkg.sv
rtl/core/cwtf_csr.sv
rtl/core/cwtf_ctrl.sv
rtl/core/cwtf_dp.sv
rtl/core/coincidence_window_trigger_filter.sv
rtl/core/cwtf_checker.sv
bench/cluster_decision_checker.sv
bench/testbench.sv
